/* design/ucb_pkg.sv */
// Shared types and constants of the uniform cubic B-spline evaluator.
package ucb_pkg;

  localparam int MaxFramesDef = 64;
  localparam int MinFrames    = 5;
  localparam int CoordW       = 32;
  localparam int TW           = 16;
  localparam int AccW         = 40;
  localparam int ScaleW       = 20;
  localparam int NumAxes      = 3;
  localparam int NumSteps     = 3;
  localparam int VclW         = 36;

  localparam logic [6:0] ResetFrames = 7'd10;

  // Largest magnitude kept before the divide by six; anything beyond saturates anyway.
  localparam logic [VclW-1:0] SatLimit = VclW'(64'd12884901894);
  // ceil(2^34 / 3), exact floor division by three for values below 2^33.
  localparam logic [32:0] Recip3 = 33'd5726623062;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqEval = 1'b1
  } req_e;

  localparam logic [1:0] OrderPos = 2'd0;
  localparam logic [1:0] OrderVel = 2'd1;
  localparam logic [1:0] OrderAcc = 2'd2;
  localparam logic [1:0] OrderBad = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [6:0]        point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]       param_t;
    logic [1:0]        deriv_order;
  } ucb_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } ucb_out_t;

  typedef logic [AccW-1:0] acc_t;
  typedef acc_t [NumAxes-1:0] acc_vec_t;
  typedef acc_vec_t [NumSteps-1:0] coef_t;

  typedef struct packed {
    logic              valid;
    logic [TW-1:0]     u;
    logic [ScaleW-1:0] scale;
  } ucb_ctl_t;

endpackage

/* design/ucb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ucb_ram #(
  parameter int Width = 96,
  parameter int Depth = 66
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ucb_horner.sv */
// One Horner step of the cubic: acc = k + round(acc * u / 2^16) on all three axes.
module ucb_horner #(
  parameter int Step = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ucb_pkg::ucb_ctl_t ctl_i,
  input  ucb_pkg::acc_vec_t acc_i,
  input  ucb_pkg::coef_t    coef_i,
  output ucb_pkg::ucb_ctl_t ctl_o,
  output ucb_pkg::acc_vec_t acc_o,
  output ucb_pkg::coef_t    coef_o
);
  import ucb_pkg::*;

  localparam int ProdW = AccW + TW + 1;

  logic              valid_q;
  logic [TW-1:0]     u_q;
  logic [ScaleW-1:0] scale_q;
  acc_vec_t acc_q, acc_d;
  coef_t    coef_q;

  logic signed [ProdW-1:0] prod [NumAxes];
  logic signed [ProdW-1:0] rsum [NumAxes];
  logic signed [ProdW-1:0] rsh  [NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      prod[a]  = $signed(acc_i[a]) * $signed({1'b0, ctl_i.u});
      rsum[a]  = prod[a] + $signed(ProdW'(32768));
      // Arithmetic shift gives the floor, so this rounds half up.
      rsh[a]   = rsum[a] >>> TW;
      acc_d[a] = acc_t'($signed(coef_i[Step][a]) + $signed(rsh[a][AccW-1:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= ctl_i.u;
      scale_q <= ctl_i.scale;
      acc_q   <= acc_d;
      coef_q  <= coef_i;
    end
  end

  assign ctl_o  = '{valid: valid_q, u: u_q, scale: scale_q};
  assign acc_o  = acc_q;
  assign coef_o = coef_q;

endmodule

/* design/ucb_post.sv */
// Derivative scaling, divide by six with rounding, and saturation to Q16.16.
module ucb_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ucb_pkg::ucb_ctl_t ctl_i,
  input  ucb_pkg::acc_vec_t acc_i,
  output logic              valid_o,
  output ucb_pkg::ucb_out_t data_o
);
  import ucb_pkg::*;

  localparam int VW = AccW + ScaleW + 1;

  // Stage A: scale and clamp.
  logic                   va_q;
  logic signed [VW-1:0]   v    [NumAxes];
  logic [VclW-1:0]        vc_d [NumAxes];
  logic [VclW-1:0]        vc_q [NumAxes];

  // Stage B: magnitude divided by six.
  logic                   vb_q;
  logic [VclW-1:0]        mag  [NumAxes];
  logic [VclW-1:0]        xr   [NumAxes];
  logic [65:0]            qp   [NumAxes];
  logic [31:0]            q_q  [NumAxes];
  logic [NumAxes-1:0]     neg_q;

  // Stage C: sign and saturation.
  logic                   vo_q;
  logic [31:0]            res  [NumAxes];
  logic [NumAxes-1:0]     sat;
  ucb_out_t               out_q, out_d;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      v[a] = $signed(acc_i[a]) * $signed({1'b0, ctl_i.scale});
      if (v[a] > $signed(VW'(SatLimit))) begin
        vc_d[a] = SatLimit;
      end else if (v[a] < -$signed(VW'(SatLimit))) begin
        vc_d[a] = -SatLimit;
      end else begin
        vc_d[a] = v[a][VclW-1:0];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      mag[a] = vc_q[a][VclW-1] ? -vc_q[a] : vc_q[a];
      xr[a]  = mag[a] + VclW'(3);
      qp[a]  = xr[a][33:1] * Recip3;
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      res[a] = neg_q[a] ? -q_q[a] : q_q[a];
      sat[a] = neg_q[a] ? (q_q[a] > 32'h8000_0000) : (q_q[a] > 32'h7fff_ffff);
      if (sat[a]) begin
        res[a] = neg_q[a] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
    out_d.out_x     = res[0];
    out_d.out_y     = res[1];
    out_d.out_z     = res[2];
    out_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= ctl_i.valid;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NumAxes; a++) begin
        vc_q[a]  <= vc_d[a];
        q_q[a]   <= qp[a][65:34];
        neg_q[a] <= vc_q[a][VclW-1];
      end
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

/* design/uniform_cubic_bspline_eval_unit.sv */
// Top level of the uniform cubic B-spline evaluator: table, front stages and pipeline.
//
//  channel   direction  payload             handshake
//  in        input      ucb_in_t            in_valid_i / in_ready_o
//  out       output     ucb_out_t           out_valid_o / out_ready_i
//  cfg       input      num_frames, 7 bits  cfg_valid_i / cfg_ready_o
//
// One item enters per cycle while in_ready_o is high; an evaluate item then passes through
// the table read, coefficients, three Horner multiplies, scale, divide and saturate stages.
// Load items write the table in the cycle they are accepted and produce no result.
// Reset clears the valid bits and sets the frame count to ten; the table is not cleared.
// When the output is held, every stage stalls together and in_ready_o drops.
module uniform_cubic_bspline_eval_unit #(
  parameter int MaxFrames = ucb_pkg::MaxFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ucb_pkg::ucb_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ucb_pkg::ucb_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);
  import ucb_pkg::*;

  localparam int Slots   = MaxFrames + 2;
  localparam int SlotW   = $clog2(Slots);
  localparam int FrameW  = $clog2(MaxFrames + 1);
  localparam int CmpW    = (FrameW > 7) ? FrameW : 7;
  localparam int IdxW    = (SlotW > 7) ? SlotW : 7;
  localparam int PtW     = 3 * CoordW;

  logic [6:0] num_frames_q;

  logic adv, accept;
  logic [CmpW-1:0] nf, fr, fm1, fm2;
  logic [TW+CmpW-1:0] pos;
  logic [CmpW-1:0] seg_raw, seg;
  logic is_eval, we;
  logic [PtW-1:0] rdata [4];

  logic              s1_valid_q;
  logic [TW-1:0]     s1_u_q;
  logic [1:0]        s1_order_q;
  logic [CmpW-1:0]   s1_fm1_q;

  logic signed [AccW-1:0] p   [4][NumAxes];
  logic signed [AccW-1:0] a0, a1, a2, a3;
  acc_vec_t          init_d;
  coef_t             coef_d;
  logic [2*CmpW-1:0] sq;
  logic [ScaleW-1:0] scale_d;

  logic              s2_valid_q;
  logic [TW-1:0]     s2_u_q;
  logic [ScaleW-1:0] s2_scale_q;
  acc_vec_t          s2_acc_q;
  coef_t             s2_coef_q;

  ucb_ctl_t ctl_q [NumSteps+1];
  acc_vec_t acc_q [NumSteps+1];
  coef_t    coef_q [NumSteps+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= ResetFrames;
    end else if (cfg_valid_i) begin
      num_frames_q <= cfg_data_i;
    end
  end

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  always_comb begin
    nf = CmpW'(num_frames_q);
    if (nf < CmpW'(MinFrames)) begin
      fr = CmpW'(MinFrames);
    end else if (nf > CmpW'(MaxFrames)) begin
      fr = CmpW'(MaxFrames);
    end else begin
      fr = nf;
    end
    fm1     = fr - CmpW'(1);
    fm2     = fr - CmpW'(2);
    pos     = in_data_i.param_t * fm1;
    seg_raw = pos[TW+CmpW-1:TW];
    seg     = (seg_raw > fm2) ? fm2 : seg_raw;
  end

  assign is_eval = (in_data_i.req_type == ReqEval);
  assign we = accept && !is_eval && (IdxW'(in_data_i.point_index) < IdxW'(Slots));

  for (genvar k = 0; k < 4; k++) begin : g_tap
    ucb_ram #(
      .Width(PtW),
      .Depth(Slots)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(SlotW'(in_data_i.point_index)),
      .wdata_i({in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x}),
      .re_i   (adv),
      .raddr_i(SlotW'(seg + CmpW'(k))),
      .rdata_o(rdata[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && is_eval && (in_data_i.deriv_order != OrderBad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_u_q     <= pos[TW-1:0];
      s1_order_q <= in_data_i.deriv_order;
      s1_fm1_q   <= fm1;
    end
  end

  // Power-basis coefficients; the Horner chain always runs three steps, so the
  // lower orders start from zero and shift their coefficients one step later per order.
  always_comb begin
    init_d = '0;
    coef_d = '0;
    for (int a = 0; a < NumAxes; a++) begin
      for (int k = 0; k < 4; k++) begin
        p[k][a] = AccW'($signed(rdata[k][a*CoordW +: CoordW]));
      end
      a0 = p[0][a] + (p[1][a] <<< 2) + p[2][a];
      a1 = 3 * (p[2][a] - p[0][a]);
      a2 = 3 * p[0][a] - 6 * p[1][a] + 3 * p[2][a];
      a3 = -p[0][a] + 3 * p[1][a] - 3 * p[2][a] + p[3][a];
      case (s1_order_q)
        OrderPos: begin
          init_d[a]    = a3;
          coef_d[0][a] = a2;
          coef_d[1][a] = a1;
          coef_d[2][a] = a0;
        end
        OrderVel: begin
          coef_d[0][a] = 3 * a3;
          coef_d[1][a] = a2 <<< 1;
          coef_d[2][a] = a1;
        end
        default: begin
          coef_d[1][a] = 6 * a3;
          coef_d[2][a] = a2 <<< 1;
        end
      endcase
    end
    sq = s1_fm1_q * s1_fm1_q;
    case (s1_order_q)
      OrderPos: scale_d = ScaleW'(1);
      OrderVel: scale_d = ScaleW'(s1_fm1_q);
      default:  scale_d = ScaleW'(sq);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_u_q     <= s1_u_q;
      s2_scale_q <= scale_d;
      s2_acc_q   <= init_d;
      s2_coef_q  <= coef_d;
    end
  end

  assign ctl_q[0]  = '{valid: s2_valid_q, u: s2_u_q, scale: s2_scale_q};
  assign acc_q[0]  = s2_acc_q;
  assign coef_q[0] = s2_coef_q;

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    ucb_horner #(
      .Step(s)
    ) u_horner (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctl_i (ctl_q[s]),
      .acc_i (acc_q[s]),
      .coef_i(coef_q[s]),
      .ctl_o (ctl_q[s+1]),
      .acc_o (acc_q[s+1]),
      .coef_o(coef_q[s+1])
    );
  end

  ucb_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl_q[NumSteps]),
    .acc_i  (acc_q[NumSteps]),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the uniform cubic B-spline evaluator with random handshakes.
module tb_top;
  import ucb_pkg::*;

  localparam int NumSlots   = MaxFramesDef + 2;
  localparam int CycleLimit = 400000;
  localparam int HoldLen    = 60;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ucb_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ucb_out_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [6:0] cfg_data_i = ResetFrames;

  uniform_cubic_bspline_eval_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the control point table and the frame count.
  logic signed [63:0] knot_tbl [NumSlots][3];
  bit         knot_written [NumSlots];
  logic [6:0] frames_reg = ResetFrames;

  ucb_in_t  pending_items[$];
  ucb_out_t expected_points[$];
  int  n_errors = 0;
  int  cycle_cnt = 0;
  bit  idle_enable = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;

  function automatic logic signed [63:0] round_q16(logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] div6_nearest(logic signed [63:0] v);
    logic signed [63:0] m;
    m = (v < 0) ? -v : v;
    m = (m + 3) / 6;
    return (v < 0) ? -m : m;
  endfunction

  // Blends the four control points of the segment holding t, as the block should.
  function automatic ucb_out_t spline_point(ucb_in_t it);
    ucb_out_t r;
    int f, seg;
    logic [31:0] pos;
    logic signed [63:0] uu, scale, p0, p1, p2, p3, a0, a1, a2, a3, acc, v;
    logic signed [31:0] res [3];
    r = '0;
    f = frames_reg;
    if (f < MinFrames) f = MinFrames;
    if (f > MaxFramesDef) f = MaxFramesDef;
    pos = it.param_t * (f - 1);
    seg = pos >> 16;
    uu = 64'(pos[15:0]);
    if (seg > f - 2) seg = f - 2;
    scale = 1;
    if (it.deriv_order >= OrderVel) scale = scale * (f - 1);
    if (it.deriv_order >= OrderAcc) scale = scale * (f - 1);
    for (int ax = 0; ax < 3; ax++) begin
      p0 = knot_tbl[seg][ax];
      p1 = knot_tbl[seg+1][ax];
      p2 = knot_tbl[seg+2][ax];
      p3 = knot_tbl[seg+3][ax];
      a0 = p0 + 4 * p1 + p2;
      a1 = 3 * (p2 - p0);
      a2 = 3 * p0 - 6 * p1 + 3 * p2;
      a3 = -p0 + 3 * p1 - 3 * p2 + p3;
      if (it.deriv_order == OrderPos) begin
        acc = a2 + round_q16(a3 * uu);
        acc = a1 + round_q16(acc * uu);
        acc = a0 + round_q16(acc * uu);
      end else if (it.deriv_order == OrderVel) begin
        acc = 2 * a2 + round_q16(3 * a3 * uu);
        acc = a1 + round_q16(acc * uu);
      end else begin
        acc = 2 * a2 + round_q16(6 * a3 * uu);
      end
      v = div6_nearest(acc * scale);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        r.saturated = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        r.saturated = 1'b1;
      end
      res[ax] = v[31:0];
    end
    r.out_x = res[0];
    r.out_y = res[1];
    r.out_z = res[2];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic ucb_in_t load_item(int idx);
    ucb_in_t it;
    it = '0;
    it.req_type = ReqLoad;
    it.point_index = 7'(idx);
    it.coord_x = rand_coord();
    it.coord_y = rand_coord();
    it.coord_z = rand_coord();
    it.param_t = 16'($urandom);
    it.deriv_order = 2'($urandom);
    return it;
  endfunction

  function automatic ucb_in_t eval_item(logic [15:0] t, logic [1:0] ord);
    ucb_in_t it;
    it = '0;
    it.req_type = ReqEval;
    it.point_index = 7'($urandom);
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    it.param_t = t;
    it.deriv_order = ord;
    return it;
  endfunction

  task automatic add_item(ucb_in_t it);
    pending_items = {pending_items, it};
  endtask

  // Input driver: the prediction is made when the item is accepted.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (in_valid_i && in_ready_o) begin
      if (in_data_i.req_type == ReqLoad) begin
        if (in_data_i.point_index < NumSlots) begin
          knot_tbl[in_data_i.point_index][0] = in_data_i.coord_x;
          knot_tbl[in_data_i.point_index][1] = in_data_i.coord_y;
          knot_tbl[in_data_i.point_index][2] = in_data_i.coord_z;
          knot_written[in_data_i.point_index] = 1'b1;
        end
      end else if (in_data_i.deriv_order != OrderBad) begin
        expected_points = {expected_points, spline_point(in_data_i)};
      end
    end
    if (!in_valid_i || in_ready_o) begin
      if (pending_items.size() > 0 && !(idle_enable && $urandom_range(0, 99) < 15)) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Counts the cycles of the long receiver hold once it has been requested.
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt < HoldLen) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Output monitor and receiver stalls.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result item");
        n_errors++;
      end else begin
        ucb_out_t e;
        e = expected_points.pop_front();
        if (out_data_o.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, out_data_o.out_x);
          n_errors++;
        end
        if (out_data_o.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, out_data_o.out_y);
          n_errors++;
        end
        if (out_data_o.out_z !== e.out_z) begin
          $error("out_z expected %0d actual %0d", e.out_z, out_data_o.out_z);
          n_errors++;
        end
        if (out_data_o.saturated !== e.saturated) begin
          $error("saturated expected %0d actual %0d", e.saturated, out_data_o.saturated);
          n_errors++;
        end
      end
    end
    if (hold_req && hold_cnt < HoldLen) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_enable && $urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_frames(logic [6:0] val);
    @(posedge clk_i);
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    frames_reg = val;
  endtask

  // Loads every slot so that no evaluation reads an unwritten entry.
  task automatic load_all();
    for (int i = 0; i < NumSlots; i++) add_item(load_item(i));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_item(load_item($urandom_range(0, NumSlots - 1)));
        1: add_item(load_item($urandom_range(NumSlots, 127)));
        2: add_item(eval_item(16'($urandom), OrderBad));
        3: add_item(eval_item(16'($urandom_range(65000, 65535)),
                              2'($urandom_range(0, 2))));
        default: add_item(eval_item(16'($urandom), 2'($urandom_range(0, 2))));
      endcase
    end
  endtask

  initial begin
    logic [6:0] frame_set [8] = '{7'd10, 7'd5, 7'd64, 7'd0, 7'd127, 7'd4, 7'd65, 7'd23};
    for (int i = 0; i < NumSlots; i++) begin
      knot_written[i] = 1'b0;
      for (int a = 0; a < 3; a++) knot_tbl[i][a] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part with the reset frame count.
    load_all();
    add_item(eval_item(16'h0000, OrderPos));
    add_item(eval_item(16'hFFFF, OrderPos));
    add_item(eval_item(16'h0000, OrderVel));
    add_item(eval_item(16'hFFFF, OrderVel));
    add_item(eval_item(16'h8000, OrderAcc));
    add_item(eval_item(16'hFFFF, OrderAcc));
    add_item(eval_item(16'h1234, OrderBad));
    add_item(load_item(127));
    add_item(load_item(NumSlots));
    add_item(eval_item(16'h7FFF, OrderPos));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_frames(frame_set[ph]);
      idle_enable = (ph != 2);
      load_all();
      if (ph == 4) begin
        // Receiver holds off while items keep coming, so the pipeline fills up.
        hold_req = 1'b1;
      end
      random_phase(120);
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
